FILE: rtl/core/lcdf_pkg.sv
// lcdf_pkg: shared types, command codes and word helpers for the lcd formatter
// no dependencies
`default_nettype none

package lcdf_pkg;

    // longest burst (window request) and the width of a word count
    localparam int WORDS_MAX = 7;
    localparam int CNT_W     = $clog2(WORDS_MAX + 1);

    // request codes
    localparam logic [1:0] REQ_WINDOW   = 2'd0;
    localparam logic [1:0] REQ_PIXEL    = 2'd1;
    localparam logic [1:0] REQ_CONTRAST = 2'd2;
    localparam logic [1:0] REQ_UNUSED   = 2'd3;

    // controller command bytes
    localparam logic [7:0] CMD_ROW_ADDR  = 8'h75;
    localparam logic [7:0] CMD_COL_ADDR  = 8'h15;
    localparam logic [7:0] CMD_MEM_WRITE = 8'h5C;
    localparam logic [7:0] CMD_CONTRAST  = 8'h81;

    // row offset of the panel
    localparam logic [7:0] ROW_OFFSET = 8'd2;

    // pixel modes
    localparam logic PIX_MODE_8  = 1'b0;
    localparam logic PIX_MODE_12 = 1'b1;

    typedef logic [8:0] t_word;

    // words of one request, words[0] goes out first
    typedef struct packed {
        t_word [WORDS_MAX-1:0] words;
        logic  [CNT_W-1:0]     count;
    } t_burst;

    // bit 8 set marks a data byte
    function automatic t_word data_word(input logic [7:0] b);
        return {1'b1, b};
    endfunction

    function automatic t_word cmd_word(input logic [7:0] b);
        return {1'b0, b};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lcdf_encoder.sv
// lcdf_encoder: turns one request into its burst of lcd words
// depends on lcdf_pkg
`default_nettype none

module lcdf_encoder import lcdf_pkg::*; (
    input  wire  [1:0]  i_req_type,
    input  wire         i_pixel_mode,
    input  wire  [7:0]  i_col_start,
    input  wire  [7:0]  i_row_start,
    input  wire  [7:0]  i_col_end,
    input  wire  [7:0]  i_row_end,
    input  wire  [11:0] i_pixel_first,
    input  wire  [11:0] i_pixel_second,
    input  wire  [15:0] i_contrast_value,
    output t_burst      o_burst
);

    logic [7:0] row_start_off;
    logic [7:0] row_end_off;

    // rows carry the panel offset, wrapping at 256
    assign row_start_off = i_row_start + ROW_OFFSET;
    assign row_end_off   = i_row_end + ROW_OFFSET;

    // word list per request type
    always_comb begin
        o_burst = '0;
        unique case (i_req_type)
            REQ_WINDOW: begin
                o_burst.words[0] = cmd_word(CMD_ROW_ADDR);
                o_burst.words[1] = data_word(row_start_off);
                o_burst.words[2] = data_word(row_end_off);
                o_burst.words[3] = cmd_word(CMD_COL_ADDR);
                o_burst.words[4] = data_word(i_col_start);
                o_burst.words[5] = data_word(i_col_end);
                o_burst.words[6] = cmd_word(CMD_MEM_WRITE);
                o_burst.count    = CNT_W'(7);
            end
            REQ_PIXEL: begin
                if (i_pixel_mode == PIX_MODE_12) begin
                    // two rgb444 pixels packed into three bytes
                    o_burst.words[0] = data_word(i_pixel_first[11:4]);
                    o_burst.words[1] = data_word({i_pixel_first[3:0], i_pixel_second[11:8]});
                    o_burst.words[2] = data_word(i_pixel_second[7:0]);
                    o_burst.count    = CNT_W'(3);
                end else begin
                    o_burst.words[0] = data_word(i_pixel_first[7:0]);
                    o_burst.count    = CNT_W'(1);
                end
            end
            REQ_CONTRAST: begin
                o_burst.words[0] = cmd_word(CMD_CONTRAST);
                o_burst.words[1] = data_word(i_contrast_value[15:8]);
                o_burst.words[2] = data_word({5'b0, i_contrast_value[2:0]});
                o_burst.count    = CNT_W'(3);
            end
            default: begin
                // unused request type gives no words
                o_burst.count = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/lcdf_sequencer.sv
// lcdf_sequencer: holds a burst and shifts it out one word a cycle into the output register
// depends on lcdf_pkg
`default_nettype none

module lcdf_sequencer import lcdf_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_load,
    input  wire t_burst  i_burst,
    output logic         o_busy,
    output logic         o_strobe,
    output t_word        o_word,
    output logic         o_last
);

    t_word [WORDS_MAX-1:0] r_words;
    t_word [WORDS_MAX-1:0] n_words;
    logic  [CNT_W-1:0]     r_left;
    logic  [CNT_W-1:0]     n_left;
    logic                  r_out_valid;
    t_word                 r_out_word;
    logic                  r_out_last;
    logic                  emit;

    assign emit = (r_left != '0);

    // a new request may enter while the final word moves to the output
    assign o_busy = (r_left > CNT_W'(1));

    // next burst contents: load a fresh one or shift by one word
    always_comb begin
        n_words = r_words;
        n_left  = r_left;
        if (emit) begin
            for (int i = 0; i < WORDS_MAX - 1; i++) begin
                n_words[i] = r_words[i+1];
            end
            n_left = r_left - CNT_W'(1);
        end
        if (i_load) begin
            n_words = i_burst.words;
            n_left  = i_burst.count;
        end
    end

    // burst store, no reset on payload
    always_ff @(posedge i_clk) begin
        r_words <= n_words;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_left      <= n_left;
            r_out_valid <= emit;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_word <= r_words[0];
            r_out_last <= (r_left == CNT_W'(1));
        end
    end

    assign o_strobe = r_out_valid;
    assign o_word   = r_out_word;
    assign o_last   = r_out_last;

endmodule

`default_nettype wire

FILE: rtl/core/lcd_window_pixel_command_formatter_top.sv
// lcd_window_pixel_command_formatter_top: request capture, pixel mode register, output words
// depends on lcdf_pkg, lcdf_encoder, lcdf_sequencer
// a taken start loads the burst store; words then pass through the output register, one per cycle
// words per request: 7 window, 3 pixel pair or contrast, 1 for an 8-bit pixel, none for an
// unused type; all of them leave through the single output word port
// busy drops in the cycle the final word is loaded, so the next start follows at once
// reset: synchronous active low, clears the burst word count and output strobe, pixel mode to 12-bit
`default_nettype none

module lcd_window_pixel_command_formatter_top import lcdf_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire         i_cfg_we,
    input  wire         i_cfg_wdata,
    input  wire  [1:0]  i_req_type,
    input  wire  [7:0]  i_col_start,
    input  wire  [7:0]  i_row_start,
    input  wire  [7:0]  i_col_end,
    input  wire  [7:0]  i_row_end,
    input  wire  [11:0] i_pixel_first,
    input  wire  [11:0] i_pixel_second,
    input  wire  [15:0] i_contrast_value,
    output logic        o_strobe,
    output logic [8:0]  o_lcd_word,
    output logic        o_last_word
);

    logic   r_pixel_mode;
    logic   load;
    t_burst burst;
    t_word  word;

    // pixel mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_mode <= PIX_MODE_12;
        end else if (i_cfg_we) begin
            r_pixel_mode <= i_cfg_wdata;
        end
    end

    assign load = start & ~busy;

    // request to word list
    lcdf_encoder u_encoder (
        .i_req_type       (i_req_type),
        .i_pixel_mode     (r_pixel_mode),
        .i_col_start      (i_col_start),
        .i_row_start      (i_row_start),
        .i_col_end        (i_col_end),
        .i_row_end        (i_row_end),
        .i_pixel_first    (i_pixel_first),
        .i_pixel_second   (i_pixel_second),
        .i_contrast_value (i_contrast_value),
        .o_burst          (burst)
    );

    // word list to output beats
    lcdf_sequencer u_sequencer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_burst  (burst),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .o_word   (word),
        .o_last   (o_last_word)
    );

    assign o_lcd_word = word;

endmodule

`default_nettype wire

FILE: test/lcd_window_pixel_command_formatter_top_tb.sv
// lcd_window_pixel_command_formatter_top_tb: self-checking bench for the lcd request formatter
// depends on lcdf_pkg and lcd_window_pixel_command_formatter_top; needs no files or arguments
// predicts every 9-bit word per request and checks each strobed word in order
`default_nettype none

module lcd_window_pixel_command_formatter_top_tb;
    import lcdf_pkg::*;

    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 30;

    // one request beat as driven on the input ports
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  col_start;
        logic [7:0]  row_start;
        logic [7:0]  col_end;
        logic [7:0]  row_end;
        logic [11:0] pixel_first;
        logic [11:0] pixel_second;
        logic [15:0] contrast_value;
    } t_lcd_request;

    // one expected output beat
    typedef struct packed {
        t_word word;
        logic  last;
    } t_lcd_beat;

    // expected word store and request formatter
    class lcd_word_scoreboard;
        t_lcd_beat pending_words[$];
        logic      mode;
        int        errors;
        int        words_checked;

        function new();
            mode          = PIX_MODE_12;
            errors        = 0;
            words_checked = 0;
        endfunction

        function int outstanding();
            return pending_words.size();
        endfunction

        // works out the words a taken request should produce
        function void note_request(t_lcd_request r);
            t_word     burst[$];
            t_lcd_beat b;
            case (r.kind)
                REQ_WINDOW: begin
                    burst.push_back({1'b0, CMD_ROW_ADDR});
                    burst.push_back({1'b1, 8'(r.row_start + ROW_OFFSET)});
                    burst.push_back({1'b1, 8'(r.row_end + ROW_OFFSET)});
                    burst.push_back({1'b0, CMD_COL_ADDR});
                    burst.push_back({1'b1, r.col_start});
                    burst.push_back({1'b1, r.col_end});
                    burst.push_back({1'b0, CMD_MEM_WRITE});
                end
                REQ_PIXEL: begin
                    if (mode == PIX_MODE_12) begin
                        burst.push_back({1'b1, r.pixel_first[11:4]});
                        burst.push_back({1'b1, r.pixel_first[3:0], r.pixel_second[11:8]});
                        burst.push_back({1'b1, r.pixel_second[7:0]});
                    end else begin
                        burst.push_back({1'b1, r.pixel_first[7:0]});
                    end
                end
                REQ_CONTRAST: begin
                    burst.push_back({1'b0, CMD_CONTRAST});
                    burst.push_back({1'b1, r.contrast_value[15:8]});
                    burst.push_back({1'b1, 5'd0, r.contrast_value[2:0]});
                end
                default: ;
            endcase
            foreach (burst[i]) begin
                b.word = burst[i];
                b.last = (i == burst.size() - 1);
                pending_words.push_back(b);
            end
        endfunction

        // compares a strobed word with the oldest expectation
        function void check_word(t_word word, logic last);
            t_lcd_beat e;
            if (pending_words.size() == 0) begin
                $error("unexpected word: lcd_word %h last_word %b", word, last);
                errors++;
                return;
            end
            e = pending_words.pop_front();
            words_checked++;
            if (word !== e.word) begin
                $error("lcd_word: expected %h, got %h", e.word, word);
                errors++;
            end
            if (last !== e.last) begin
                $error("last_word: expected %b, got %b", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic [1:0]  i_req_type = '0;
    logic [7:0]  i_col_start = '0;
    logic [7:0]  i_row_start = '0;
    logic [7:0]  i_col_end = '0;
    logic [7:0]  i_row_end = '0;
    logic [11:0] i_pixel_first = '0;
    logic [11:0] i_pixel_second = '0;
    logic [15:0] i_contrast_value = '0;
    logic        o_strobe;
    logic [8:0]  o_lcd_word;
    logic        o_last_word;

    lcd_word_scoreboard sb = new();
    int req_seen [4];
    int mode_writes;
    int cycle_count;

    lcd_window_pixel_command_formatter_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_req_type       (i_req_type),
        .i_col_start      (i_col_start),
        .i_row_start      (i_row_start),
        .i_col_end        (i_col_end),
        .i_row_end        (i_row_end),
        .i_pixel_first    (i_pixel_first),
        .i_pixel_second   (i_pixel_second),
        .i_contrast_value (i_contrast_value),
        .o_strobe         (o_strobe),
        .o_lcd_word       (o_lcd_word),
        .o_last_word      (o_last_word)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still due", cycle_count,
                     sb.outstanding());
            $display("lcd_window_pixel_command_formatter_top_tb: done, errors");
            $finish;
        end
    end

    // monitor: register writes, taken requests and strobed words
    always @(posedge i_clk) begin
        t_lcd_request r;
        if (i_rst_n) begin
            if (o_strobe)
                sb.check_word(o_lcd_word, o_last_word);
            if (i_cfg_we)
                sb.mode = i_cfg_wdata;
            if (start && !busy) begin
                r = '{i_req_type, i_col_start, i_row_start, i_col_end, i_row_end,
                      i_pixel_first, i_pixel_second, i_contrast_value};
                sb.note_request(r);
                req_seen[i_req_type]++;
            end
        end
    end

    // random request, mostly valid types with a few unused ones
    function automatic t_lcd_request random_request();
        t_lcd_request r;
        int pick;
        pick = $urandom_range(99);
        if (pick < 30)
            r.kind = REQ_WINDOW;
        else if (pick < 65)
            r.kind = REQ_PIXEL;
        else if (pick < 93)
            r.kind = REQ_CONTRAST;
        else
            r.kind = REQ_UNUSED;
        r.col_start      = 8'($urandom_range(255));
        r.row_start      = 8'($urandom_range(255));
        r.col_end        = 8'($urandom_range(255));
        r.row_end        = 8'($urandom_range(255));
        r.pixel_first    = 12'($urandom_range(4095));
        r.pixel_second   = 12'($urandom_range(4095));
        r.contrast_value = 16'($urandom_range(65535));
        // pin some fields to their extremes now and then
        if ($urandom_range(7) == 0) r.row_start = 8'hFF - 8'($urandom_range(1));
        if ($urandom_range(7) == 0) r.row_end   = 8'hFF - 8'($urandom_range(1));
        if ($urandom_range(9) == 0) r.pixel_first  = $urandom_range(1) ? 12'hFFF : 12'h000;
        if ($urandom_range(9) == 0) r.contrast_value = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        return r;
    endfunction

    // drives one request and returns at the edge it is taken
    task automatic send_request(t_lcd_request r, int idle_pct);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_req_type       <= r.kind;
        i_col_start      <= r.col_start;
        i_row_start      <= r.row_start;
        i_col_end        <= r.col_end;
        i_row_end        <= r.row_end;
        i_pixel_first    <= r.pixel_first;
        i_pixel_second   <= r.pixel_second;
        i_contrast_value <= r.contrast_value;
        do
            @(posedge i_clk);
        while (busy);
    endtask

    // lets the block go idle, then writes the pixel mode register
    task automatic settle_and_set_mode(logic m);
        start <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        mode_writes++;
    endtask

    // directed request with the unused fields left random, or all ones for the unused type
    task automatic send_directed(logic [1:0] kind, logic [7:0] cs, logic [7:0] rs,
                                 logic [7:0] ce, logic [7:0] re, logic [11:0] p1,
                                 logic [11:0] p2, logic [15:0] cv);
        t_lcd_request r;
        r = random_request();
        r.kind = kind;
        if (kind == REQ_WINDOW) begin
            r.col_start = cs;
            r.row_start = rs;
            r.col_end   = ce;
            r.row_end   = re;
        end else if (kind == REQ_PIXEL) begin
            r.pixel_first  = p1;
            r.pixel_second = p2;
        end else if (kind == REQ_CONTRAST) begin
            r.contrast_value = cv;
        end else begin
            r = '1;
        end
        send_request(r, 0);
    endtask

    // stimulus
    initial begin
        int idle_pcts [6];
        logic modes [6];
        idle_pcts = '{0, 85, 37, 0, 85, 37};
        modes     = '{PIX_MODE_12, PIX_MODE_8, PIX_MODE_12, PIX_MODE_8, PIX_MODE_12,
                      PIX_MODE_8};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: 12-bit mode from reset
        send_directed(REQ_WINDOW, 8'h00, 8'h00, 8'h00, 8'h00, '0, '0, '0);
        send_directed(REQ_WINDOW, 8'hFF, 8'hFF, 8'hFF, 8'hFE, '0, '0, '0);
        // reversed window with rows wrapping past the offset
        send_directed(REQ_WINDOW, 8'hC8, 8'hFE, 8'h0A, 8'h01, '0, '0, '0);
        send_directed(REQ_PIXEL, '0, '0, '0, '0, 12'h000, 12'h000, '0);
        send_directed(REQ_PIXEL, '0, '0, '0, '0, 12'hFFF, 12'hFFF, '0);
        send_directed(REQ_PIXEL, '0, '0, '0, '0, 12'hABC, 12'h123, '0);
        send_directed(REQ_CONTRAST, '0, '0, '0, '0, '0, '0, 16'h0000);
        send_directed(REQ_CONTRAST, '0, '0, '0, '0, '0, '0, 16'hFFFF);
        send_directed(REQ_CONTRAST, '0, '0, '0, '0, '0, '0, 16'h12FD);
        // unused request type gives no words
        send_directed(REQ_UNUSED, '0, '0, '0, '0, '0, '0, '0);
        send_directed(REQ_PIXEL, '0, '0, '0, '0, 12'h5A5, 12'hA5A, '0);

        // directed: 8-bit mode, upper pixel bits and second pixel ignored
        settle_and_set_mode(PIX_MODE_8);
        send_directed(REQ_PIXEL, '0, '0, '0, '0, 12'hFFF, 12'hFFF, '0);
        send_directed(REQ_PIXEL, '0, '0, '0, '0, 12'h000, 12'hFFF, '0);
        send_directed(REQ_PIXEL, '0, '0, '0, '0, 12'hFA5, 12'h000, '0);
        send_directed(REQ_UNUSED, '0, '0, '0, '0, '0, '0, '0);
        send_directed(REQ_WINDOW, 8'h01, 8'h80, 8'h7F, 8'hFD, '0, '0, '0);
        send_directed(REQ_CONTRAST, '0, '0, '0, '0, '0, '0, 16'h8007);
        send_directed(REQ_PIXEL, '0, '0, '0, '0, 12'h0FF, 12'h000, '0);

        // random phases, the mode changing between them
        foreach (idle_pcts[p]) begin
            settle_and_set_mode(modes[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_request(random_request(), idle_pcts[p]);
        end

        // drain and let the last burst finish
        start <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("requests taken: %0d window, %0d pixel, %0d contrast, %0d unused",
                 req_seen[REQ_WINDOW], req_seen[REQ_PIXEL], req_seen[REQ_CONTRAST],
                 req_seen[REQ_UNUSED]);
        $display("%0d words checked over %0d pixel mode writes, %0d mismatches",
                 sb.words_checked, mode_writes, sb.errors);
        if (sb.errors == 0)
            $display("lcd_window_pixel_command_formatter_top_tb: done, clean");
        else
            $display("lcd_window_pixel_command_formatter_top_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
